@@ sv/rcam_pkg.sv @@
// Shared constants and types for the rounded corner alpha mask pipeline.
// Depends on nothing; compiled before the top level.
package rcam_pkg;

  localparam int FB        = 8;
  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = 12;
  localparam int CH_W      = 16;
  localparam int N_CH      = 4;
  localparam int DIM_W     = 13;
  localparam int RAD_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = RAD_W;

  localparam int FIX_W  = DIM_W + FB;
  localparam int POS_W  = COORD_W + FB;
  localparam int GAP_W  = POS_W;
  localparam int SQR_W  = 2 * GAP_W;
  localparam int SUM_W  = SQR_W + 1;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int SQ_W   = SUM_W + 1;
  localparam int DIST_W = ROOT_W + 1;
  localparam int COV_W  = FB + 1;
  localparam int PROD_W = CH_W + COV_W;

  localparam logic [COV_W-1:0] ONE  = COV_W'(1) << FB;
  localparam logic [FB-1:0]    HALF = FB'(1) << (FB - 1);

  localparam int ST_RAW   = 0;
  localparam int ST_GAP   = 1;
  localparam int ST_SQR   = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_SQRT0 = 4;
  localparam int N_SQRT   = ROOT_W;
  localparam int ST_DIST  = ST_SQRT0 + N_SQRT;
  localparam int ST_COV   = ST_DIST + 1;
  localparam int ST_OUT   = ST_COV + 1;
  localparam int N_STAGES = ST_OUT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_index_e;

  typedef logic [N_CH-1:0][CH_W-1:0] chan_t;

endpackage

@@ sv/rounded_corner_alpha_mask_top.sv @@
// Rounded corner coverage mask: scales a premultiplied RGBA pixel stream
// by the coverage of a rounded rectangle. Depends on rcam_pkg.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------------
//  in      | in_valid_i  | in_stall_o  | pixel_column_i, pixel_row_i, in_*_i
//  out     | out_valid_o | out_stall_i | out_red_o .. out_alpha_o
//  cfg     | cfg_we_i    | none        | cfg_index_i, cfg_data_i
//
// One item is taken per clock while in_stall_o is low.
// The pipeline has 28 stages, of which the square root
// takes 21 stages, one result bit per stage.
// Reset clears the valid bits and restores the register defaults.
// A stall only holds stages that are full, so bubbles are squeezed out.
module rounded_corner_alpha_mask_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcam_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rcam_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rcam_pkg::COORD_W-1:0]        pixel_column_i,
  input  logic [rcam_pkg::COORD_W-1:0]        pixel_row_i,
  input  logic [rcam_pkg::CH_W-1:0]           in_red_i,
  input  logic [rcam_pkg::CH_W-1:0]           in_green_i,
  input  logic [rcam_pkg::CH_W-1:0]           in_blue_i,
  input  logic [rcam_pkg::CH_W-1:0]           in_alpha_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rcam_pkg::CH_W-1:0]           out_red_o,
  output logic [rcam_pkg::CH_W-1:0]           out_green_o,
  output logic [rcam_pkg::CH_W-1:0]           out_blue_o,
  output logic [rcam_pkg::CH_W-1:0]           out_alpha_o
);
  import rcam_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry that follows from the registers, kept in its own registers.
  logic [DIM_W-1:0] wcl, hcl;
  logic [FIX_W-1:0] wfix, hfix;
  logic [RAD_W-1:0] rc_d, rc_q;
  logic [FIX_W-1:0] hix_d, hix_q, hiy_d, hiy_q, lim_d, lim_q;
  logic             byp_d, byp_q;

  always_comb begin
    wcl = width_q;
    if (width_q == '0) wcl = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_DIM)) wcl = DIM_W'(MAX_DIM);
    hcl = height_q;
    if (height_q == '0) hcl = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_DIM)) hcl = DIM_W'(MAX_DIM);
    wfix = FIX_W'(wcl) << FB;
    hfix = FIX_W'(hcl) << FB;
    rc_d = radius_q;
    if (FIX_W'(rc_d) > (wfix >> 1)) rc_d = RAD_W'(wfix >> 1);
    if (FIX_W'(rc_d) > (hfix >> 1)) rc_d = RAD_W'(hfix >> 1);
    hix_d = wfix - FIX_W'(rc_d);
    hiy_d = hfix - FIX_W'(rc_d);
    lim_d = FIX_W'(rc_d) + FIX_W'(HALF);
    byp_d = (radius_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      hix_q <= FIX_W'(ONE);
      hiy_q <= FIX_W'(ONE);
      lim_q <= FIX_W'(HALF);
      byp_q <= 1'b1;
    end else begin
      rc_q  <= rc_d;
      hix_q <= hix_d;
      hiy_q <= hiy_d;
      lim_q <= lim_d;
      byp_q <= byp_d;
    end
  end

  // Stage advance: a stage moves unless it and every later stage are full
  // while the output is stalled.
  logic [N_STAGES-1:0] v_q, en;

  always_comb begin
    for (int k = 0; k < N_STAGES; k++) begin
      en[k] = !(out_stall_i && (&(v_q | ((N_STAGES'(1) << k) - N_STAGES'(1)))));
    end
  end

  assign in_stall_o  = !en[ST_RAW];
  assign out_valid_o = v_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[ST_RAW]) v_q[ST_RAW] <= in_valid_i;
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  chan_t ch_q [ST_OUT];

  always_ff @(posedge clk_i) begin
    if (en[ST_RAW]) ch_q[ST_RAW] <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    for (int k = 1; k < ST_OUT; k++) begin
      if (en[k]) ch_q[k] <= ch_q[k-1];
    end
  end

  logic [COORD_W-1:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_RAW]) begin
      col_q <= pixel_column_i;
      row_q <= pixel_row_i;
    end
  end

  // Distance from the pixel center to the inner rectangle, per axis.
  logic [POS_W-1:0] px, py;
  logic [GAP_W-1:0] dx_d, dy_d, dx_q, dy_q;

  always_comb begin
    px = (POS_W'(col_q) << FB) + POS_W'(HALF);
    py = (POS_W'(row_q) << FB) + POS_W'(HALF);
    dx_d = '0;
    if (px < rc_q) dx_d = rc_q - px;
    else if (FIX_W'(px) > hix_q) dx_d = GAP_W'(FIX_W'(px) - hix_q);
    dy_d = '0;
    if (py < rc_q) dy_d = rc_q - py;
    else if (FIX_W'(py) > hiy_q) dy_d = GAP_W'(FIX_W'(py) - hiy_q);
  end

  logic [SQR_W-1:0] sqx_q, sqy_q;
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_GAP]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (en[ST_SQR]) begin
      sqx_q <= dx_q * dx_q;
      sqy_q <= dy_q * dy_q;
    end
    if (en[ST_SUM]) sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
  end

  // Square root, one result bit per stage, most significant bit first.
  logic [ROOT_W-1:0] root_q [N_SQRT];
  logic [SUM_W-1:0]  rem_q  [N_SQRT];

  for (genvar j = 0; j < N_SQRT; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [SUM_W-1:0]  rem_in, rem_d;
    logic [SQ_W-1:0]   trial;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = sum_q;
    end else begin : g_next
      assign root_in = root_q[j-1];
      assign rem_in  = rem_q[j-1];
    end

    always_comb begin
      trial  = (SQ_W'(root_in) << (K + 1)) | (SQ_W'(1) << (2 * K));
      root_d = root_in;
      rem_d  = rem_in;
      if (SQ_W'(rem_in) >= trial) begin
        rem_d  = rem_in - SUM_W'(trial);
        root_d = root_in | (ROOT_W'(1) << K);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_SQRT0 + j]) begin
        root_q[j] <= root_d;
        rem_q[j]  <= rem_d;
      end
    end
  end

  logic [DIST_W-1:0] dist_q;
  logic [COV_W-1:0]  cov_d, cov_q;
  logic [DIST_W-1:0] cov_diff;

  always_comb begin
    cov_diff = DIST_W'(lim_q) - dist_q;
    if (byp_q) cov_d = ONE;
    else if (DIST_W'(lim_q) <= dist_q) cov_d = '0;
    else if (cov_diff > DIST_W'(ONE)) cov_d = ONE;
    else cov_d = cov_diff[COV_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIST]) begin
      dist_q <= DIST_W'(root_q[N_SQRT-1])
              + DIST_W'(rem_q[N_SQRT-1] > SUM_W'(root_q[N_SQRT-1]));
    end
    if (en[ST_COV]) cov_q <= cov_d;
  end

  // Output register: each channel times coverage, rounded.
  chan_t            out_d, out_q;
  logic [PROD_W-1:0] prod [N_CH];

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      prod[c]  = PROD_W'(ch_q[ST_OUT-1][c]) * PROD_W'(cov_q) + PROD_W'(HALF);
      out_d[c] = prod[c][FB +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) out_q <= out_d;
  end

  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_COV] |-> cov_q <= ONE)
    else $error("coverage above one");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_COV] && byp_q) |-> cov_q == ONE)
    else $error("zero radius did not give full coverage");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_DIST-1] |-> rem_q[N_SQRT-1] <= (SUM_W'(root_q[N_SQRT-1]) << 1))
    else $error("square root remainder out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q && out_stall_i))
    else $error("input stalled while the pipeline has a bubble");

endmodule
